// ===== sv/i2d_pkg.sv =====
// ----------------------------------------------------------------------------
// i2d_pkg
// shared types and constants for the integer to decimal text converter
// ----------------------------------------------------------------------------
package i2d_pkg;

    typedef logic [7:0] t_char;

    localparam t_char CHAR_ZERO  = 8'h30;
    localparam t_char CHAR_MINUS = 8'h2D;

    // magnitude bits shifted through the bcd converter per pipeline stage
    localparam int BITS_PER_STAGE = 4;

endpackage

// ===== sv/i2d_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// i2d_dabble_stage
// one pipeline stage of the shift and add-3 binary to bcd converter
// ----------------------------------------------------------------------------
module i2d_dabble_stage import i2d_pkg::*; #(
    parameter int DIGITS   = 10,
    parameter int MAG_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_neg,
    input  logic [DIGITS*4-1:0]   i_bcd,
    input  logic [MAG_BITS-1:0]   i_bin,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_neg,
    output logic [DIGITS*4-1:0]   o_bcd,
    output logic [MAG_BITS-1:0]   o_bin
);

    logic                r_valid;
    logic                r_neg;
    logic [DIGITS*4-1:0] r_bcd;
    logic [MAG_BITS-1:0] r_bin;
    logic [DIGITS*4-1:0] n_bcd;
    logic [MAG_BITS-1:0] n_bin;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_bcd = i_bcd;
        n_bin = i_bin;
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (n_bcd[d*4 +: 4] >= 4'd5) begin
                    n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[DIGITS*4-2:0], n_bin[MAG_BITS-1]};
            n_bin = {n_bin[MAG_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_neg <= i_neg;
            r_bcd <= n_bcd;
            r_bin <= n_bin;
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_bcd   = r_bcd;
    assign o_bin   = r_bin;

endmodule

// ===== sv/i2d_serializer.sv =====
// ----------------------------------------------------------------------------
// i2d_serializer
// emits sign and digits of one converted number, one character per cycle
// ----------------------------------------------------------------------------
module i2d_serializer import i2d_pkg::*; #(
    parameter int DIGITS = 10,
    parameter int IDX_W  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_neg,
    input  logic [DIGITS*4-1:0] i_bcd,
    input  logic [IDX_W-1:0]    i_top,
    output logic                o_strobe,
    output t_char               o_character,
    output logic                o_last
);

    logic             r_active;
    logic             r_neg_pend;
    logic [IDX_W-1:0] r_idx;
    logic [3:0]       r_dig [DIGITS];
    logic             r_strobe;
    t_char            r_char;
    logic             r_last;
    logic             fin;
    t_char            cur_char;

    assign fin      = !r_neg_pend && (r_idx == '0);
    assign o_ready  = !r_active || fin;
    assign cur_char = r_neg_pend ? CHAR_MINUS : (CHAR_ZERO | {4'b0000, r_dig[r_idx]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (o_ready && i_valid) begin
                r_active <= 1'b1;
            end else if (r_active && fin) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= cur_char;
        r_last <= fin;
        if (o_ready && i_valid) begin
            r_neg_pend <= i_neg;
            r_idx      <= i_top;
            for (int d = 0; d < DIGITS; d++) begin
                r_dig[d] <= i_bcd[d*4 +: 4];
            end
        end else if (r_active) begin
            if (r_neg_pend) begin
                r_neg_pend <= 1'b0;
            end else if (r_idx != '0) begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

// ===== sv/signed_int_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// signed integer to decimal ascii text, one character per output word
//
//   channel | ports                              | handshake
//   --------+------------------------------------+-----------------------------
//   input   | i_value                            | start high, busy low
//   output  | o_character, o_last                | o_strobe, one cycle, no stall
//
// a number of n characters (digits plus sign) is emitted one character per cycle;
// runs of consecutive numbers follow without a gap.
// the first character passes through the input register, the bcd stages,
// the digit scan, the serializer and the output register.
// busy rises only when the character serializer is behind and the pipe is full.
// synchronous active-low reset empties the pipe and the serializer.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top import i2d_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_strobe,
    output logic [7:0]                    o_character,
    output logic                          o_last
);

    localparam int ND  = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int MB  = ((VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE)
                         * BITS_PER_STAGE;
    localparam int NST = MB / BITS_PER_STAGE;
    localparam int IW  = $clog2(ND);

    // slot 0 is the input register, slot k+1 the output of bcd stage k
    logic              st_v   [NST+1];
    logic              st_neg [NST+1];
    logic [ND*4-1:0]   st_bcd [NST+1];
    logic [MB-1:0]     st_bin [NST+1];
    logic              st_rdy [NST+1];

    logic              r_s0_valid;
    logic              r_s0_neg;
    logic [MB-1:0]     r_s0_mag;
    logic              s0_ready;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;

    logic              r_sc_valid;
    logic              r_sc_neg;
    logic [ND*4-1:0]   r_sc_bcd;
    logic [IW-1:0]     r_sc_top;
    logic [IW-1:0]     n_top;
    logic              sc_ready;
    logic              ser_ready;

    // input register: sign and unsigned magnitude
    assign raw      = i_value;
    assign mag      = raw[VALUE_WIDTH-1] ? VALUE_WIDTH'(~raw + 1'b1) : raw;
    assign s0_ready = !r_s0_valid || st_rdy[0];
    assign busy     = !s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && s0_ready) begin
            r_s0_neg <= raw[VALUE_WIDTH-1];
            r_s0_mag <= MB'(mag);
        end
    end

    assign st_v[0]   = r_s0_valid;
    assign st_neg[0] = r_s0_neg;
    assign st_bcd[0] = '0;
    assign st_bin[0] = r_s0_mag;

    // bcd conversion pipe
    for (genvar k = 0; k < NST; k++) begin : g_dabble
        i2d_dabble_stage #(
            .DIGITS   (ND),
            .MAG_BITS (MB)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_v[k]),
            .o_ready (st_rdy[k]),
            .i_neg   (st_neg[k]),
            .i_bcd   (st_bcd[k]),
            .i_bin   (st_bin[k]),
            .o_valid (st_v[k+1]),
            .i_ready (st_rdy[k+1]),
            .o_neg   (st_neg[k+1]),
            .o_bcd   (st_bcd[k+1]),
            .o_bin   (st_bin[k+1])
        );
    end

    // digit scan: index of the leading nonzero digit, zero gives index 0
    assign sc_ready     = !r_sc_valid || ser_ready;
    assign st_rdy[NST]  = sc_ready;

    always_comb begin
        n_top = '0;
        for (int d = 0; d < ND; d++) begin
            if (st_bcd[NST][d*4 +: 4] != 4'd0) begin
                n_top = IW'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_valid <= 1'b0;
        end else if (sc_ready) begin
            r_sc_valid <= st_v[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sc_ready && st_v[NST]) begin
            r_sc_neg <= st_neg[NST];
            r_sc_bcd <= st_bcd[NST];
            r_sc_top <= n_top;
        end
    end

    i2d_serializer #(
        .DIGITS (ND),
        .IDX_W  (IW)
    ) u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_sc_valid),
        .o_ready     (ser_ready),
        .i_neg       (r_sc_neg),
        .i_bcd       (r_sc_bcd),
        .i_top       (r_sc_top),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // a run of characters has no gap before its last word
    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("character run broken before last word");

    // the sign never ends a number
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_character == CHAR_MINUS) |-> !o_last)
        else $error("minus sign flagged as last");

    // no leading zero after the sign
    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_character == CHAR_MINUS) |=> (o_character != CHAR_ZERO))
        else $error("leading zero after minus sign");

    // an accepted word lands in the input register
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_s0_valid)
        else $error("accepted word lost at input register");

endmodule

// ===== bench/tb_signed_int_to_decimal_ascii_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_top
// self-checking bench for the signed integer to decimal ascii converter
//
// each accepted number is turned into its expected character run by a local
// predictor and queued; every strobed output word is compared with the oldest
// queued character and its last flag. directed values cover zero, the
// extremes and the digit-count boundaries, then shaped random numbers follow,
// sent in bursts with random gaps and in one stretch with no gaps at all.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_top;
    import i2d_pkg::*;

    localparam int  VALUE_WIDTH  = 32;
    localparam real CLK_PERIOD   = 12.0;
    localparam int  LATENCY      = VALUE_WIDTH / 4 + 4;
    localparam int  MAX_CHARS    = 11;
    localparam int  CYCLE_LIMIT  = 200000;

    typedef struct packed {
        t_char character;
        logic  last;
    } t_text_char;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [VALUE_WIDTH-1:0] i_value = '0;
    logic                          o_strobe;
    logic [7:0]                    o_character;
    logic                          o_last;

    t_text_char pending_chars[$];
    int         mismatch_count = 0;
    int         numbers_sent   = 0;
    int         numbers_done   = 0;
    int         chars_checked  = 0;
    int         negative_sent  = 0;
    int         cycle_count    = 0;
    int         burst_left     = 0;
    int         gap_max        = 20;

    signed_int_to_decimal_ascii_top #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    initial begin
        forever #(CLK_PERIOD / 2.0) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters still expected",
                     cycle_count, pending_chars.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // queue the decimal text of one number, sign first, last flag on final digit
    function automatic void push_decimal_text(input logic signed [VALUE_WIDTH-1:0] num);
        logic [VALUE_WIDTH-1:0] mag;
        t_char                  digits[24];
        int                     n_digits;
        logic                   negative;
        negative = num[VALUE_WIDTH-1];
        // unsigned negate keeps the most negative value exact
        mag      = negative ? (~num + 1'b1) : num;
        n_digits = 0;
        if (mag == '0) begin
            pending_chars.push_back('{character: CHAR_ZERO, last: 1'b1});
            return;
        end
        while (mag != '0) begin
            digits[n_digits] = CHAR_ZERO + t_char'(mag % 10);
            mag              = mag / 10;
            n_digits++;
        end
        if (negative)
            pending_chars.push_back('{character: CHAR_MINUS, last: 1'b0});
        for (int i = n_digits - 1; i >= 0; i--)
            pending_chars.push_back('{character: digits[i], last: (i == 0)});
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // output words cannot be held off, so every strobe is checked at its edge
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_strobe) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected word char=%02h last=%0b",
                                          o_character, o_last));
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (o_character !== want.character)
                    report_mismatch($sformatf("char %02h, expected %02h",
                                              o_character, want.character));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b on char %02h",
                                              o_last, want.last, want.character));
                if (want.last)
                    numbers_done++;
            end
        end
    end

    // hold start until accepted, then either keep the burst going or idle
    task automatic send_value(input logic signed [VALUE_WIDTH-1:0] num);
        int gap;
        start   <= 1'b1;
        i_value <= num;
        do @(posedge i_clk); while (busy);
        push_decimal_text(num);
        numbers_sent++;
        if (num[VALUE_WIDTH-1])
            negative_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(0, gap_max);
            burst_left = $urandom_range(0, 7);
            if (gap > 0) begin
                start   <= 1'b0;
                i_value <= $urandom;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // number with a random digit count, near a power of ten, near the largest magnitude, or fully random
    function automatic logic signed [VALUE_WIDTH-1:0] shaped_value();
        longint mag;
        longint pow10;
        int     n_digits;
        pow10 = 1;
        case ($urandom_range(0, 3))
            0: begin
                return $urandom;
            end
            1: begin
                n_digits = $urandom_range(1, 10);
                for (int i = 0; i < n_digits; i++)
                    pow10 = pow10 * 10;
                mag = {$urandom, $urandom} % pow10;
            end
            2: begin
                n_digits = $urandom_range(0, 9);
                for (int i = 0; i < n_digits; i++)
                    pow10 = pow10 * 10;
                mag = pow10 + $signed($urandom_range(0, 2)) - 1;
            end
            default: begin
                mag = 64'sd2147483647 - $urandom_range(0, 3);
            end
        endcase
        if (mag > 64'sd2147483647)
            mag = 64'sd2147483647;
        if ($urandom_range(0, 1))
            mag = -mag;
        return mag[VALUE_WIDTH-1:0];
    endfunction

    task automatic test_small_values();
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(-9);
        send_value(10);
        send_value(-10);
        send_value(99);
        send_value(100);
    endtask

    task automatic test_extremes();
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        send_value(32'sh8000_0001);
        send_value(32'sh5555_5555);
        send_value(32'shAAAA_AAAA);
        send_value(0);
    endtask

    task automatic test_digit_boundaries();
        send_value(999_999_999);
        send_value(1_000_000_000);
        send_value(-1_000_000_000);
        send_value(-999_999_999);
        send_value(123_456_789);
        send_value(-876_543_210);
    endtask

    task automatic test_random_values(input int count);
        for (int i = 0; i < count; i++)
            send_value(shaped_value());
    endtask

    // no idle cycles at all, so the serializer falls behind and busy rises
    task automatic test_back_to_back(input int count);
        int saved_gap;
        saved_gap = gap_max;
        gap_max   = 0;
        for (int i = 0; i < count; i++)
            send_value(($urandom_range(0, 3) == 0) ? 32'sh8000_0000 : shaped_value());
        gap_max = saved_gap;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_small_values();
        test_extremes();
        test_digit_boundaries();
        test_random_values(60);
        test_back_to_back(24);
        test_random_values(30);

        start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (LATENCY + MAX_CHARS) @(posedge i_clk);

        $display("sent %0d numbers (%0d negative), checked %0d characters over %0d numbers",
                 numbers_sent, negative_sent, chars_checked, numbers_done);
        $display("covered zero, both extremes, digit-count edges, gapped and gapless bursts");
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d characters left over",
                     mismatch_count, pending_chars.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
